>>> src/crfq_pkg.sv
// types and constants shared by the can receive frame queue
`timescale 1ns / 1ps
`default_nettype none

package crfq_pkg;

    // longest data field of a classic can frame, in bytes
    localparam int unsigned MAX_FRAME_BYTES = 8;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // one request: a received frame or a pop
    typedef struct packed {
        logic        operation;
        logic        extended_format;
        logic [10:0] standard_id;
        logic [28:0] extended_id;
        logic        remote_request;
        logic [3:0]  data_length_code;
        logic [63:0] payload;
    } crfq_req_t;

    // one result
    typedef struct packed {
        logic        push_accepted;
        logic        frame_valid;
        logic [28:0] frame_id;
        logic [3:0]  frame_length;
        logic [63:0] frame_bytes;
        logic        queue_not_empty;
        logic [31:0] dropped_total;
        logic [31:0] stored_total;
    } crfq_res_t;

    // contents of one queue slot
    typedef struct packed {
        logic [28:0] id;
        logic [3:0]  length;
        logic [63:0] bytes;
    } crfq_slot_t;

endpackage

`default_nettype wire

>>> src/can_rx_frame_queue_unit.sv
// can receive frame queue: ring of frame slots with stored and dropped counters
//
//  channel   ports                    handshake
//  request   start, busy, request     taken when start is high and busy is low
//  result    done, result             one cycle strobe, cannot be held off
//
// every request gives one result in the cycle after it is taken
// busy stays low: a request can be taken in every cycle, one slot memory read per request and one
// write per accepted push, pointers and counters update in the same cycle
// reset clears pointers and counters; slot contents are undefined until written
// a full ring holds QUEUE_SLOTS-1 frames
`timescale 1ns / 1ps
`default_nettype none

module can_rx_frame_queue_unit
    import crfq_pkg::*;
#(
    parameter int unsigned QUEUE_SLOTS = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire crfq_req_t request,
    output logic           done,
    output crfq_res_t      result
);

    localparam int unsigned IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);

    // slot memory
    crfq_slot_t slot_mem [QUEUE_SLOTS];

    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [31:0]      drop_cnt_reg, drop_cnt_next;
    logic [31:0]      store_cnt_reg, store_cnt_next;
    logic             done_reg;
    logic             accepted_reg, accepted_next;
    logic             valid_reg, valid_next;
    crfq_slot_t       rd_data_reg;

    logic             take;
    logic             do_write;
    logic [IDX_W-1:0] wr_adv;
    logic [IDX_W-1:0] rd_adv;
    logic [3:0]       store_len;
    logic [63:0]      store_bytes;
    crfq_slot_t       wr_slot;

    assign busy = 1'b0;
    assign take = start && !busy;

    // ring pointer advance
    assign wr_adv = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_adv = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;

    // length: zero for remote frames, dlc saturated at eight otherwise
    always_comb
    begin
        if (request.remote_request)
        begin
            store_len = 4'd0;
        end
        else if (request.data_length_code > 4'(MAX_FRAME_BYTES))
        begin
            store_len = 4'(MAX_FRAME_BYTES);
        end
        else
        begin
            store_len = request.data_length_code;
        end
    end

    // zero bytes beyond the length
    always_comb
    begin
        for (int i = 0; i < MAX_FRAME_BYTES; i++)
        begin
            store_bytes[i*8 +: 8] = (4'(i) < store_len) ? request.payload[i*8 +: 8] : 8'h00;
        end
    end

    // slot contents for a push
    always_comb
    begin
        wr_slot.id     = request.extended_format ? request.extended_id
                                                 : {18'd0, request.standard_id};
        wr_slot.length = store_len;
        wr_slot.bytes  = store_bytes;
    end

    // next pointer, counter and status values
    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        drop_cnt_next  = drop_cnt_reg;
        store_cnt_next = store_cnt_reg;
        accepted_next  = 1'b0;
        valid_next     = 1'b0;
        do_write       = 1'b0;
        if (take)
        begin
            if (request.operation == OP_PUSH)
            begin
                if (wr_adv == rd_ptr_reg)
                begin
                    drop_cnt_next = drop_cnt_reg + 32'd1;
                end
                else
                begin
                    do_write       = 1'b1;
                    wr_ptr_next    = wr_adv;
                    store_cnt_next = store_cnt_reg + 32'd1;
                    accepted_next  = 1'b1;
                end
            end
            else if (rd_ptr_reg != wr_ptr_reg)
            begin
                valid_next  = 1'b1;
                rd_ptr_next = rd_adv;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            drop_cnt_reg  <= '0;
            store_cnt_reg <= '0;
            done_reg      <= 1'b0;
            accepted_reg  <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            drop_cnt_reg  <= drop_cnt_next;
            store_cnt_reg <= store_cnt_next;
            done_reg      <= take;
            accepted_reg  <= accepted_next;
            valid_reg     <= valid_next;
        end
    end

    // slot memory write
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slot_mem[wr_ptr_reg] <= wr_slot;
        end
    end

    // slot memory read at the read pointer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_data_reg <= slot_mem[rd_ptr_reg];
        end
    end

    // result assembly from registered state
    always_comb
    begin
        result.push_accepted   = accepted_reg;
        result.frame_valid     = valid_reg;
        result.frame_id        = valid_reg ? rd_data_reg.id : '0;
        result.frame_length    = valid_reg ? rd_data_reg.length : '0;
        result.frame_bytes     = valid_reg ? rd_data_reg.bytes : '0;
        result.queue_not_empty = (wr_ptr_reg != rd_ptr_reg);
        result.dropped_total   = drop_cnt_reg;
        result.stored_total    = store_cnt_reg;
    end

    assign done = done_reg;

endmodule

`default_nettype wire
